>>> src/rpn_stack_calculator_assert.svh
// Assertion macros for the calculator checker.
// Both sample on clk and are switched off while rst_n is low.
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define RSC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define RSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rsc_pkg.sv
package rsc_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 20;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // Field widths
  localparam int CMD_W       = 3;
  localparam int Q_W         = 32;
  localparam int FRAC_W      = 16;
  localparam int DEPTH_OUT_W = 5;

  // Divider geometry: |a| << 16 plus half the divisor
  localparam int DIV_NUM_W = Q_W + FRAC_W;
  localparam int DIV_DEN_W = Q_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd5;

  // Q16.16 range limits
  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh80000000;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [Q_W-1:0]   operand_value;
  } in_t;

  typedef struct packed {
    logic signed [Q_W-1:0]   result_value;
    logic [DEPTH_OUT_W-1:0]  stack_depth;
    logic                    overflow_flag;
    logic                    underflow_flag;
    logic                    divide_by_zero_flag;
    logic                    saturated_flag;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic do_push;
    logic do_pop;
    logic latch_a;
    logic latch_b;
    logic start_op;
    logic write_back;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             op_done;
  } dp_status_t;

endpackage

>>> src/rsc_divider.sv
module rsc_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rsc_pkg::DIV_NUM_W-1:0] dividend,
  input  logic [rsc_pkg::DIV_DEN_W-1:0] divisor,
  output logic                          busy,
  output logic [rsc_pkg::DIV_NUM_W-1:0] quotient
);
  import rsc_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_r, quo_r[DIV_NUM_W-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = shifted >= {1'b0, den_r};
    rem_nxt = ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
  end

  // Iteration count and busy flag
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_NUM_W);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Quotient shifts in from the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_NUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

>>> src/rsc_datapath.sv
module rsc_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  rsc_pkg::ctrl_cmd_t  cmd,
  input  rsc_pkg::in_t        in_data,
  output rsc_pkg::out_t       out_data,
  output rsc_pkg::dp_status_t status
);
  import rsc_pkg::*;

  localparam logic signed [2*Q_W-1:0] MUL_HI   = 64'sh000000007FFFFFFF;
  localparam logic signed [2*Q_W-1:0] MUL_LO   = 64'shFFFFFFFF80000000;
  localparam logic signed [2*Q_W-1:0] MUL_HALF = 64'sh0000000000008000;

  // Stack storage and depth
  logic [Q_W-1:0]    stack_mem_r [STACK_DEPTH];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [Q_W-1:0]    mem_rd_r;
  logic              rd_ok_r;

  // Request and operand registers
  logic [CMD_W-1:0]        cmd_code_r;
  logic signed [Q_W-1:0]   val_r;
  logic signed [Q_W-1:0]   a_r, b_r;
  logic signed [2*Q_W-1:0] prod_r;
  logic signed [Q_W-1:0]   res_r;
  logic                    over_r, under_r, dz_r, sat_r;
  out_t                    out_r;

  logic                    not_full, not_empty;
  logic [CNT_W-1:0]        cnt_m1;
  logic [ADDR_W-1:0]       wr_addr, rd_addr;
  logic                    wr_en;
  logic [Q_W-1:0]          wr_data;
  logic signed [Q_W-1:0]   pop_val;

  logic signed [2*Q_W-1:0] prod_full;
  logic signed [Q_W:0]     sum33;
  logic signed [2*Q_W-1:0] mul_rnd, mul_sh;
  logic [Q_W-1:0]          abs_a, abs_b;
  logic [DIV_NUM_W-1:0]    div_num, quot, neg_q;
  logic                    div_start, div_busy;
  logic signed [Q_W-1:0]   calc_res;
  logic                    calc_sat, calc_dz;

  // Stack pointers
  always_comb begin
    not_full  = count_r < CNT_W'(STACK_DEPTH);
    not_empty = count_r != '0;
    cnt_m1    = count_r - CNT_W'(1);
    wr_addr   = count_r[ADDR_W-1:0];
    rd_addr   = cnt_m1[ADDR_W-1:0];
    pop_val   = rd_ok_r ? mem_rd_r : '0;
  end

  // Write port: a pushed value or a computed result
  always_comb begin
    wr_en   = 1'b0;
    wr_data = val_r;
    if (cmd.do_push && not_full) begin
      wr_en = 1'b1;
    end else if (cmd.write_back && not_full) begin
      wr_en   = 1'b1;
      wr_data = calc_res;
    end
  end

  // Depth follows writes and successful pops
  always_comb begin
    count_nxt = count_r;
    if (wr_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.do_pop && not_empty) begin
      count_nxt = cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Stack memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem_r[wr_addr] <= wr_data;
    end
    if (cmd.do_pop && not_empty) begin
      mem_rd_r <= stack_mem_r[rd_addr];
    end
  end

  // Multiplier feeds a register before rounding
  assign prod_full = a_r * b_r;

  // Divider operands: magnitudes, dividend pre-biased by half the divisor
  always_comb begin
    abs_a     = a_r[Q_W-1] ? (Q_W'(0) - a_r) : a_r;
    abs_b     = b_r[Q_W-1] ? (Q_W'(0) - b_r) : b_r;
    div_num   = {abs_a, FRAC_W'(0)} + DIV_NUM_W'(abs_b >> 1);
    div_start = cmd.start_op && (cmd_code_r == CMD_DIV);
  end

  rsc_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (abs_b),
    .busy     (div_busy),
    .quotient (quot)
  );

  // Final result per arithmetic command, clamped to Q16.16
  always_comb begin
    sum33    = (cmd_code_r == CMD_SUB) ? ({a_r[Q_W-1], a_r} - {b_r[Q_W-1], b_r})
                                       : ({a_r[Q_W-1], a_r} + {b_r[Q_W-1], b_r});
    mul_rnd  = prod_r + MUL_HALF;
    mul_sh   = mul_rnd >>> FRAC_W;
    neg_q    = DIV_NUM_W'(0) - quot;
    calc_res = '0;
    calc_sat = 1'b0;
    calc_dz  = 1'b0;
    unique case (cmd_code_r) inside
      CMD_ADD, CMD_SUB: begin
        if (sum33[Q_W] != sum33[Q_W-1]) begin
          calc_sat = 1'b1;
          calc_res = sum33[Q_W] ? Q_MIN : Q_MAX;
        end else begin
          calc_res = sum33[Q_W-1:0];
        end
      end
      CMD_MUL: begin
        if (mul_sh > MUL_HI) begin
          calc_sat = 1'b1;
          calc_res = Q_MAX;
        end else if (mul_sh < MUL_LO) begin
          calc_sat = 1'b1;
          calc_res = Q_MIN;
        end else begin
          calc_res = mul_sh[Q_W-1:0];
        end
      end
      CMD_DIV: begin
        if (b_r == '0) begin
          // zero divisor: saturate by dividend sign, zero over zero is zero
          calc_dz = 1'b1;
          if (a_r > 0) begin
            calc_sat = 1'b1;
            calc_res = Q_MAX;
          end else if (a_r < 0) begin
            calc_sat = 1'b1;
            calc_res = Q_MIN;
          end
        end else if (a_r[Q_W-1] ^ b_r[Q_W-1]) begin
          if (quot > DIV_NUM_W'(48'h80000000)) begin
            calc_sat = 1'b1;
            calc_res = Q_MIN;
          end else begin
            calc_res = neg_q[Q_W-1:0];
          end
        end else begin
          if (quot > DIV_NUM_W'(48'h7FFFFFFF)) begin
            calc_sat = 1'b1;
            calc_res = Q_MAX;
          end else begin
            calc_res = quot[Q_W-1:0];
          end
        end
      end
      default: calc_res = '0;
    endcase
  end

  // Request, operand and flag registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_code_r <= in_data.command;
      val_r      <= in_data.operand_value;
      res_r      <= '0;
      over_r     <= 1'b0;
      under_r    <= 1'b0;
      dz_r       <= 1'b0;
      sat_r      <= 1'b0;
    end
    if (cmd.do_push) begin
      if (not_full) begin
        res_r <= val_r;
      end else begin
        over_r <= 1'b1;
      end
    end
    if (cmd.do_pop) begin
      rd_ok_r <= not_empty;
      if (!not_empty) begin
        under_r <= 1'b1;
      end
    end
    if (cmd.latch_a) begin
      a_r   <= pop_val;
      res_r <= pop_val;
    end
    if (cmd.latch_b) begin
      b_r <= pop_val;
    end
    if (cmd.start_op) begin
      prod_r <= prod_full;
    end
    if (cmd.write_back) begin
      res_r <= calc_res;
      sat_r <= calc_sat;
      dz_r  <= calc_dz;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.result_value        <= res_r;
      out_r.stack_depth         <= DEPTH_OUT_W'(count_r);
      out_r.overflow_flag       <= over_r;
      out_r.underflow_flag      <= under_r;
      out_r.divide_by_zero_flag <= dz_r;
      out_r.saturated_flag      <= sat_r;
    end
  end

  assign out_data       = out_r;
  assign status.cmd     = cmd_code_r;
  assign status.op_done = !div_busy;

endmodule

>>> src/rsc_ctrl.sv
module rsc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rsc_pkg::dp_status_t status,
  output rsc_pkg::ctrl_cmd_t  cmd
);
  import rsc_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_GET_A    = 3'd2;
  localparam logic [2:0] S_GET_B    = 3'd3;
  localparam logic [2:0] S_OP_START = 3'd4;
  localparam logic [2:0] S_OP_WAIT  = 3'd5;
  localparam logic [2:0] S_WB       = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status.cmd) inside
          CMD_PUSH: begin
            cmd.do_push = 1'b1;
            state_nxt   = S_DONE;
          end
          CMD_POP, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
            cmd.do_pop = 1'b1;
            state_nxt  = S_GET_A;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_GET_A: begin
        cmd.latch_a = 1'b1;
        if (status.cmd == CMD_POP) begin
          state_nxt = S_DONE;
        end else begin
          cmd.do_pop = 1'b1;
          state_nxt  = S_GET_B;
        end
      end
      S_GET_B: begin
        cmd.latch_b = 1'b1;
        state_nxt   = S_OP_START;
      end
      S_OP_START: begin
        cmd.start_op = 1'b1;
        state_nxt    = S_OP_WAIT;
      end
      S_OP_WAIT: begin
        if (status.op_done) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        cmd.write_back = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        // hand over once the output register is free or being drained
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output request valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> src/rpn_stack_calculator.sv
// Channel  Ports                          Payload
// -------  -----------------------------  ------------------------------------
// in       in_valid, in_ready, in_data    command, operand_value
// out      out_valid, out_ready, out_data result_value, stack_depth, flags
//
// One request at a time; push is quickest, then pop, then add/sub/mul, and divide
// is slowest: its wait is set by the restoring divider, one quotient bit per
// cycle over 48 bits. The stack is a 20-entry memory with a registered read.
// rst_n is synchronous and empties the stack; no clearing pass is needed.
// A finished result waits in the output register while the next request runs.
module rpn_stack_calculator (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rsc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rsc_pkg::out_t out_data
);
  import rsc_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  rsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (dp_status),
    .cmd       (ctrl_cmd)
  );

  rsc_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (ctrl_cmd),
    .in_data  (in_data),
    .out_data (out_data),
    .status   (dp_status)
  );

endmodule

>>> src/rsc_checker.sv
`include "rpn_stack_calculator_assert.svh"

module rsc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input rsc_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input rsc_pkg::out_t out_data
);
  import rsc_pkg::*;

  // A stalled result request holds
  `RSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "out request changed while stalled")

  // One request at a time: no accept right after an accept
  `RSC_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input accepted while busy")

  // Depth never passes the stack size
  `RSC_ASSERT_SAME(a_depth_bound, out_valid, out_data.stack_depth <= DEPTH_OUT_W'(STACK_DEPTH), "stack depth out of range")

  // Zero divisor saturates exactly when the result is nonzero
  `RSC_ASSERT_SAME(a_div_zero, out_valid && out_data.divide_by_zero_flag, !out_data.overflow_flag && (out_data.saturated_flag == (out_data.result_value != 0)), "bad divide by zero result")

endmodule

bind rpn_stack_calculator rsc_checker u_rsc_checker (.*);

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import rsc_pkg::*;

  localparam int RUN_LIMIT     = 400000;
  localparam int SETTLE_CYCLES = 64;

  // Codes the block leaves undefined; it must do nothing for them
  localparam logic [CMD_W-1:0] CMD_SPARE0 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE1 = 3'd7;

  localparam logic signed [63:0] Q_TOP    = 64'sd2147483647;
  localparam logic signed [63:0] Q_BOTTOM = -64'sd2147483648;

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  logic  in_ready;
  in_t   in_data   = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  out_t  out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold_len = 0;
  int hold_left     = 0;
  int bad_results   = 0;
  int cycle_count   = 0;

  // Shadow copy of the operand stack
  logic signed [Q_W-1:0] shadow_stack [STACK_DEPTH];
  int                    shadow_depth = 0;
  out_t                  due_results [$];

  rpn_stack_calculator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Calculator prediction
  // ---------------------------------------------------------------------------

  // Empty stack reads as zero and raises underflow; depth stays put
  function automatic logic signed [63:0] shadow_pop(inout bit under);
    if (shadow_depth == 0) begin
      under = 1'b1;
      return 64'sd0;
    end
    shadow_depth--;
    return shadow_stack[shadow_depth];
  endfunction

  function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v,
                                                 inout bit sat);
    if (v > Q_TOP) begin
      sat = 1'b1;
      return Q_TOP;
    end
    if (v < Q_BOTTOM) begin
      sat = 1'b1;
      return Q_BOTTOM;
    end
    return v;
  endfunction

  // a / b in Q16.16, rounded half away from zero
  function automatic logic signed [63:0] q_divide(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  inout bit sat, inout bit dz);
    logic [63:0] ua, ub, quo;
    if (b == 0) begin
      dz = 1'b1;
      if (a > 0) begin
        sat = 1'b1;
        return Q_TOP;
      end
      if (a < 0) begin
        sat = 1'b1;
        return Q_BOTTOM;
      end
      return 64'sd0;
    end
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    quo = ((ua << 16) + (ub >> 1)) / ub;
    if ((a < 0) != (b < 0)) begin
      if (quo > 64'h80000000) begin
        sat = 1'b1;
        return Q_BOTTOM;
      end
      return -$signed(quo);
    end
    if (quo > 64'h7FFFFFFF) begin
      sat = 1'b1;
      return Q_TOP;
    end
    return $signed(quo);
  endfunction

  // Apply one command to the shadow stack and return the expected result
  function automatic out_t run_command(input in_t req);
    out_t                  r;
    logic signed [63:0]    a, b, res;
    logic signed [Q_W-1:0] val;
    bit                    over, under, dz, sat;
    over  = 1'b0;
    under = 1'b0;
    dz    = 1'b0;
    sat   = 1'b0;
    res   = 64'sd0;
    val   = req.operand_value;
    case (req.command) inside
      CMD_PUSH: begin
        if (shadow_depth < STACK_DEPTH) begin
          shadow_stack[shadow_depth] = val;
          shadow_depth++;
          res = val;
        end else begin
          over = 1'b1;
        end
      end
      CMD_POP: begin
        res = shadow_pop(under);
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        // top first, then the one below
        a = shadow_pop(under);
        b = shadow_pop(under);
        case (req.command)
          CMD_ADD: res = clamp_q(a + b, sat);
          CMD_SUB: res = clamp_q(a - b, sat);
          CMD_MUL: res = clamp_q((a * b + 64'sd32768) >>> 16, sat);
          default: res = q_divide(a, b, sat, dz);
        endcase
        if (shadow_depth < STACK_DEPTH) begin
          shadow_stack[shadow_depth] = res[Q_W-1:0];
          shadow_depth++;
        end
      end
      default: ;
    endcase
    r.result_value        = res[Q_W-1:0];
    r.stack_depth         = DEPTH_OUT_W'(shadow_depth);
    r.overflow_flag       = over;
    r.underflow_flag      = under;
    r.divide_by_zero_flag = dz;
    r.saturated_flag      = sat;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  function automatic in_t calc_req(input logic [CMD_W-1:0] cmd,
                                   input logic signed [Q_W-1:0] val);
    in_t r;
    r.command       = cmd;
    r.operand_value = val;
    return r;
  endfunction

  // Mostly modest magnitudes so mul/div don't always clamp
  function automatic logic signed [Q_W-1:0] pick_operand();
    case ($urandom_range(7))
      0, 1, 2: return $urandom_range(1 << 20) - (1 << 19);
      3:       return $urandom_range(32'h1FFFF) - 32'h10000;
      4:       return $urandom_range(1 << 25) - (1 << 24);
      5: begin
        case ($urandom_range(4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Valid stays up across back-to-back requests; dropped only for a gap
  task automatic send_req(input in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    due_results.push_back(run_command(req));
  endtask

  task automatic drain_stack();
    while (shadow_depth > 0) send_req(calc_req(CMD_POP, $urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Ready pattern, with an optional long hold-off counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (recv_hold_len > 0) begin
        hold_left     = recv_hold_len;
        recv_hold_len = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each result with the oldest pending one
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result with no pending request: result_value %0d", out_data.result_value);
        bad_results++;
      end else begin
        want = due_results.pop_front();
        if (out_data.result_value !== want.result_value) begin
          $error("result_value: expected %0d, got %0d",
                 want.result_value, out_data.result_value);
          bad_results++;
        end
        if (out_data.stack_depth !== want.stack_depth) begin
          $error("stack_depth: expected %0d, got %0d",
                 want.stack_depth, out_data.stack_depth);
          bad_results++;
        end
        if (out_data.overflow_flag !== want.overflow_flag) begin
          $error("overflow_flag: expected %0b, got %0b",
                 want.overflow_flag, out_data.overflow_flag);
          bad_results++;
        end
        if (out_data.underflow_flag !== want.underflow_flag) begin
          $error("underflow_flag: expected %0b, got %0b",
                 want.underflow_flag, out_data.underflow_flag);
          bad_results++;
        end
        if (out_data.divide_by_zero_flag !== want.divide_by_zero_flag) begin
          $error("divide_by_zero_flag: expected %0b, got %0b",
                 want.divide_by_zero_flag, out_data.divide_by_zero_flag);
          bad_results++;
        end
        if (out_data.saturated_flag !== want.saturated_flag) begin
          $error("saturated_flag: expected %0b, got %0b",
                 want.saturated_flag, out_data.saturated_flag);
          bad_results++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extreme values through push/pop, then a pop on the empty stack
  task automatic test_stack_edges();
    send_req(calc_req(CMD_PUSH, Q_MAX));
    send_req(calc_req(CMD_PUSH, Q_MIN));
    send_req(calc_req(CMD_POP, $urandom));
    send_req(calc_req(CMD_POP, $urandom));
    send_req(calc_req(CMD_POP, $urandom));
  endtask

  // add, sub and mul clamping to the Q16.16 range
  task automatic test_saturation();
    send_req(calc_req(CMD_PUSH, Q_MAX));
    send_req(calc_req(CMD_PUSH, 32'sh00010000));
    send_req(calc_req(CMD_ADD, $urandom));
    send_req(calc_req(CMD_PUSH, Q_MIN));
    send_req(calc_req(CMD_SUB, $urandom));
    send_req(calc_req(CMD_PUSH, 32'sh00030000));
    send_req(calc_req(CMD_MUL, $urandom));
  endtask

  // Zero divisor with positive, negative and zero dividend
  task automatic test_divide_by_zero();
    send_req(calc_req(CMD_PUSH, 32'sd0));
    send_req(calc_req(CMD_PUSH, 32'sh00050000));
    send_req(calc_req(CMD_DIV, $urandom));
    send_req(calc_req(CMD_PUSH, 32'sd0));
    send_req(calc_req(CMD_PUSH, -32'sd1));
    send_req(calc_req(CMD_DIV, $urandom));
    send_req(calc_req(CMD_PUSH, 32'sd0));
    send_req(calc_req(CMD_PUSH, 32'sd0));
    send_req(calc_req(CMD_DIV, $urandom));
    drain_stack();
  endtask

  // Arithmetic on an empty stack, and the spare command codes
  task automatic test_empty_and_unused();
    send_req(calc_req(CMD_ADD, $urandom));
    send_req(calc_req(CMD_SPARE0, $urandom));
    send_req(calc_req(CMD_SPARE1, $urandom));
    send_req(calc_req(CMD_POP, $urandom));
  endtask

  // Stack-aware command mix with a little noise mixed in
  task automatic test_random_traffic(input int count, input int send_pct,
                                     input int recv_pct);
    int               pick;
    logic [CMD_W-1:0] cmd;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 3)
        cmd = $urandom_range(1) ? CMD_SPARE1 : CMD_SPARE0;
      else if (pick < 8)
        cmd = CMD_W'($urandom_range(CMD_DIV));
      else if (shadow_depth >= STACK_DEPTH - 1)
        cmd = (pick < 15) ? CMD_PUSH : CMD_ADD + CMD_W'($urandom_range(CMD_DIV - CMD_ADD));
      else if (shadow_depth < 2 || pick < 50)
        cmd = CMD_PUSH;
      else if (pick < 56)
        cmd = CMD_POP;
      else
        cmd = CMD_ADD + CMD_W'($urandom_range(CMD_DIV - CMD_ADD));
      send_req(calc_req(cmd, pick_operand()));
    end
  endtask

  // Long result stall while requests keep coming: fills and overflows the stack
  task automatic test_output_backpressure();
    drain_stack();
    recv_hold_len = 400;
    repeat (STACK_DEPTH + 2) send_req(calc_req(CMD_PUSH, pick_operand()));
    repeat (6) send_req(calc_req($urandom_range(1) ? CMD_DIV : CMD_MUL, $urandom));
    drain_stack();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 13;
    recv_idle_pct = 61;
    test_stack_edges();
    test_saturation();
    test_divide_by_zero();
    test_empty_and_unused();

    test_random_traffic(390, 13, 61);
    test_output_backpressure();
    test_random_traffic(390, 61, 13);
    test_random_traffic(390, 0, 0);

    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_results == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
